[src/bitmap_duplicate_remover_unit_assert.svh]
// Assertion macros for the bitmap duplicate remover.
`ifndef BITMAP_DUPLICATE_REMOVER_UNIT_ASSERT_SVH
`define BITMAP_DUPLICATE_REMOVER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define BDR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define BDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BDR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BDR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/bdr_pkg.sv]
// Package: constants, payload types and control structs of the duplicate remover.
package bdr_pkg;

  localparam int unsigned VALUE_RANGE  = 4096;
  localparam int unsigned MAX_LIST     = 1024;
  localparam int unsigned VALUE_W      = 12;
  localparam int unsigned KEPT_COUNT_W = 11;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned BIT_SEL_W    = 3;

  function automatic int unsigned clog2_min1(int unsigned n);
    return (n <= 2) ? 1 : $clog2(n);
  endfunction

  localparam int unsigned BM_DEPTH = (VALUE_RANGE + 7) / 8;
  localparam int unsigned BM_AW    = clog2_min1(BM_DEPTH);
  localparam int unsigned KL_AW    = clog2_min1(MAX_LIST);
  localparam int unsigned CNT_W    = $clog2(MAX_LIST + 1);
  localparam int unsigned IDX_W    = (BM_AW > CNT_W) ? BM_AW : CNT_W;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]      kept_value;
    logic [KEPT_COUNT_W-1:0] kept_count;
    logic                    is_end;
  } out_item_t;

  typedef struct packed {
    logic cap;        // capture input item
    logic keep;       // record new value, load kept result
    logic load_end;   // load end result
    logic init_wr;    // zero one bitmap byte of the reset sweep
    logic clr_rd;     // read one kept list entry for clearing
    logic idx_clr;    // zero the sweep index
    logic count_clr;  // zero the unique count
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_new;
    logic last;
    logic out_free;
    logic count_zero;
    logic idx_bm_end;
    logic idx_clr_end;
  } dp_status_t;

endpackage

[src/bitmap_duplicate_remover_unit.sv]
// Bitmap duplicate remover: drops repeated values of a list, keeping first occurrences
// in order, and ends each list with a result carrying the number of values kept.
// After reset the seen-bitmap is zeroed one byte per cycle, all 512 bytes, before the
// first item is taken. Each item then passes through transfer, bitmap read, and test and
// set, steps given by the input register and the registered read of the bitmap memory; a
// kept result waits in an output register, and the next item is taken while it waits. A
// second kept result holds in the test cycle until the output register frees up. After
// the last item of a list the end result is loaded in its own step, held while the
// output register is full; then, with N values kept, the bitmap bytes of the kept values
// are zeroed from the kept list, one per cycle, or none when N is zero.
module bitmap_duplicate_remover_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bdr_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bdr_pkg::out_item_t out_data_o
);

  `include "bitmap_duplicate_remover_unit_assert.svh"

  bdr_pkg::ctrl_cmd_t  cmd;
  bdr_pkg::dp_status_t sts;

  bdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bdr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .sts_o       (sts)
  );

  // A result loads only into a free output slot.
  `BDR_ASSERT_IMPL(a_load_slot_free, clk_i, rst_ni, cmd.keep || cmd.load_end, sts.out_free)
  // No item is taken while the bitmap is being cleared.
  `BDR_ASSERT_IMPL(a_no_accept_clear, clk_i, rst_ni, cmd.init_wr || cmd.clr_rd, !in_ready_o)
  // A loaded result is shown in the next cycle.
  `BDR_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, cmd.keep || cmd.load_end, out_valid_o)

endmodule

[src/bdr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bdr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/bdr_datapath.sv]
// Datapath: item registers, seen-bitmap and kept list memories, count, output register.
module bdr_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bdr_pkg::in_item_t     in_data_i,
  input  bdr_pkg::ctrl_cmd_t    cmd_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output bdr_pkg::out_item_t    out_data_o,
  output bdr_pkg::dp_status_t   sts_o
);

  logic [bdr_pkg::VALUE_W-1:0]   value_q;
  logic                          last_q;
  logic [bdr_pkg::CNT_W-1:0]     count_q, count_d;
  logic [bdr_pkg::IDX_W-1:0]     idx_q, idx_d, idx_inc;
  logic                          clr_wr_q;
  bdr_pkg::out_item_t            out_q, out_d;
  logic                          out_valid_q, out_valid_d;

  logic [bdr_pkg::BM_AW-1:0]     bm_raddr, bm_waddr;
  logic [bdr_pkg::BYTE_W-1:0]    bm_rdata, bm_wdata, bit_mask;
  logic [bdr_pkg::BIT_SEL_W-1:0] bit_sel;
  logic                          bm_we;
  logic [bdr_pkg::VALUE_W-1:0]   kl_rdata;
  logic                          in_range;

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      value_q <= in_data_i.value;
      last_q  <= in_data_i.last;
    end
  end

  assign bm_raddr = bdr_pkg::BM_AW'(value_q >> bdr_pkg::BIT_SEL_W);
  assign bit_sel  = value_q[bdr_pkg::BIT_SEL_W-1:0];
  assign bit_mask = bdr_pkg::BYTE_W'(1) << bit_sel;
  assign in_range = 32'(value_q) < bdr_pkg::VALUE_RANGE;

  // Clearing writes a whole byte to zero: every set bit belongs to this list.
  assign bm_we = cmd_i.keep | cmd_i.init_wr | clr_wr_q;

  always_comb begin
    if (cmd_i.init_wr) begin
      bm_waddr = bdr_pkg::BM_AW'(idx_q);
    end else if (clr_wr_q) begin
      bm_waddr = bdr_pkg::BM_AW'(kl_rdata >> bdr_pkg::BIT_SEL_W);
    end else begin
      bm_waddr = bm_raddr;
    end
  end

  assign bm_wdata = cmd_i.keep ? (bm_rdata | bit_mask) : '0;

  bdr_ram #(
    .Width (bdr_pkg::BYTE_W),
    .Depth (bdr_pkg::BM_DEPTH)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  bdr_ram #(
    .Width (bdr_pkg::VALUE_W),
    .Depth (bdr_pkg::MAX_LIST)
  ) u_kept_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.keep),
    .waddr_i (count_q[bdr_pkg::KL_AW-1:0]),
    .wdata_i (value_q),
    .raddr_i (idx_q[bdr_pkg::KL_AW-1:0]),
    .rdata_o (kl_rdata)
  );

  assign idx_inc = idx_q + bdr_pkg::IDX_W'(1);

  always_comb begin
    count_d = count_q;
    if (cmd_i.count_clr) begin
      count_d = '0;
    end else if (cmd_i.keep) begin
      count_d = count_q + bdr_pkg::CNT_W'(1);
    end

    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.init_wr || cmd_i.clr_rd) begin
      idx_d = idx_inc;
    end

    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (cmd_i.keep) begin
      out_d.kept_value = value_q;
      out_d.kept_count = bdr_pkg::KEPT_COUNT_W'(count_q + bdr_pkg::CNT_W'(1));
      out_d.is_end     = 1'b0;
      out_valid_d      = 1'b1;
    end else if (cmd_i.load_end) begin
      out_d.kept_value = '0;
      out_d.kept_count = bdr_pkg::KEPT_COUNT_W'(count_q);
      out_d.is_end     = 1'b1;
      out_valid_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      clr_wr_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      clr_wr_q    <= cmd_i.clr_rd;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.is_new      = in_range && (count_q < bdr_pkg::CNT_W'(bdr_pkg::MAX_LIST))
                             && !bm_rdata[bit_sel];
  assign sts_o.last        = last_q;
  assign sts_o.out_free    = ~out_valid_q | out_ready_i;
  assign sts_o.count_zero  = (count_q == '0);
  assign sts_o.idx_bm_end  = (idx_q == bdr_pkg::IDX_W'(bdr_pkg::BM_DEPTH - 1));
  assign sts_o.idx_clr_end = (idx_inc == bdr_pkg::IDX_W'(count_q));

endmodule

[src/bdr_ctrl.sv]
// Controller: sequences reset sweep, item test-and-set, end result and list clearing.
module bdr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bdr_pkg::dp_status_t  sts_i,
  output bdr_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [2:0] S_INIT     = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_READ     = 3'd2;
  localparam logic [2:0] S_CHECK    = 3'd3;
  localparam logic [2:0] S_END      = 3'd4;
  localparam logic [2:0] S_CLR      = 3'd5;
  localparam logic [2:0] S_CLR_LAST = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.idx_bm_end) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        // hold until the output register can take the kept result
        if (!sts_i.is_new || sts_i.out_free) begin
          cmd_o.keep = sts_i.is_new;
          state_d    = sts_i.last ? S_END : S_IDLE;
        end
      end
      S_END: begin
        if (sts_i.out_free) begin
          cmd_o.load_end = 1'b1;
          cmd_o.idx_clr  = 1'b1;
          state_d        = sts_i.count_zero ? S_IDLE : S_CLR;
        end
      end
      S_CLR: begin
        cmd_o.clr_rd = 1'b1;
        if (sts_i.idx_clr_end) begin
          state_d = S_CLR_LAST;
        end
      end
      S_CLR_LAST: begin
        // last bitmap write lands here
        cmd_o.count_clr = 1'b1;
        cmd_o.idx_clr   = 1'b1;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sim/tb_bitmap_duplicate_remover_unit.sv]
// Testbench for the bitmap duplicate remover: directed and random lists checked against a predictor.
`timescale 1ns / 1ps

module tb_bitmap_duplicate_remover_unit;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned REPORT_MAX  = 30;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  bdr_pkg::in_item_t  in_data   = '0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  bdr_pkg::out_item_t out_data;

  bitmap_duplicate_remover_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // Predictor state
  logic [bdr_pkg::BYTE_W-1:0]  seen_bytes [bdr_pkg::BM_DEPTH];
  logic [bdr_pkg::VALUE_W-1:0] kept_values [bdr_pkg::MAX_LIST];
  int unsigned                 unique_total;
  bdr_pkg::out_item_t          awaited_results [$];

  int unsigned error_count  = 0;
  int unsigned stall_cycles = 0;
  int unsigned rx_hold_left = 0;
  bit          no_idle      = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void predict_dedup(input bdr_pkg::in_item_t item);
    int unsigned        byte_idx;
    int unsigned        bit_idx;
    bdr_pkg::out_item_t res;
    byte_idx = 32'(item.value >> bdr_pkg::BIT_SEL_W);
    bit_idx  = 32'(item.value[bdr_pkg::BIT_SEL_W-1:0]);
    if (32'(item.value) < bdr_pkg::VALUE_RANGE && unique_total < bdr_pkg::MAX_LIST) begin
      if (!seen_bytes[byte_idx][bit_idx]) begin
        seen_bytes[byte_idx][bit_idx] = 1'b1;
        kept_values[unique_total] = item.value;
        unique_total++;
        res.kept_value = item.value;
        res.kept_count = bdr_pkg::KEPT_COUNT_W'(unique_total);
        res.is_end     = 1'b0;
        awaited_results.push_back(res);
      end
    end
    if (item.last) begin
      res.kept_value = '0;
      res.kept_count = bdr_pkg::KEPT_COUNT_W'(unique_total);
      res.is_end     = 1'b1;
      awaited_results.push_back(res);
      // clear only the bits of values kept in this list
      for (int unsigned k = 0; k < unique_total; k++) begin
        seen_bytes[kept_values[k] >> bdr_pkg::BIT_SEL_W]
                  [kept_values[k][bdr_pkg::BIT_SEL_W-1:0]] = 1'b0;
      end
      unique_total = 0;
    end
  endfunction

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    error_count++;
    if (error_count <= REPORT_MAX)
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
  endtask

  // Drive the next item at the falling edge; valid stays high between back-to-back items.
  task automatic send_item(input logic [bdr_pkg::VALUE_W-1:0] value, input logic last_flag);
    bdr_pkg::in_item_t item;
    item.value = value;
    item.last  = last_flag;
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
    predict_dedup(item);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // Extremes, repeats, duplicate on the last item, single-item list, reuse after clearing.
  task automatic test_directed();
    send_item(12'd0, 1'b0);
    send_item(12'd4095, 1'b0);
    send_item(12'd0, 1'b0);
    send_item(12'd4095, 1'b0);
    send_item(12'd2048, 1'b0);
    send_item(12'd1, 1'b0);
    send_item(12'd7, 1'b0);
    send_item(12'd8, 1'b0);
    send_item(12'd4088, 1'b0);
    send_item(12'd4095, 1'b1);
    send_item(12'd4095, 1'b1);
    send_item(12'd5, 1'b0);
    send_item(12'd5, 1'b0);
    send_item(12'd5, 1'b1);
    send_item(12'd0, 1'b0);
    send_item(12'd4095, 1'b1);
    stop_sending();
  endtask

  // Fill the kept list, offer new values past the limit, then show their bits stayed clear.
  task automatic test_list_full();
    logic [bdr_pkg::VALUE_W-1:0] order [bdr_pkg::VALUE_RANGE];
    logic [bdr_pkg::VALUE_W-1:0] tmp;
    int unsigned                 j;
    for (int unsigned i = 0; i < bdr_pkg::VALUE_RANGE; i++) order[i] = bdr_pkg::VALUE_W'(i);
    for (int unsigned i = bdr_pkg::VALUE_RANGE - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int unsigned i = 0; i < bdr_pkg::MAX_LIST; i++) send_item(order[i], 1'b0);
    for (int unsigned i = bdr_pkg::MAX_LIST; i < bdr_pkg::MAX_LIST + 3; i++)
      send_item(order[i], 1'b0);
    for (int i = 0; i < 2; i++) send_item(order[$urandom_range(bdr_pkg::MAX_LIST - 1)], 1'b0);
    send_item(order[bdr_pkg::MAX_LIST + 3], 1'b1);
    for (int unsigned i = bdr_pkg::MAX_LIST; i < bdr_pkg::MAX_LIST + 4; i++)
      send_item(order[i], 1'b0);
    send_item(order[0], 1'b1);
    stop_sending();
  endtask

  // Hold the receiver off while items keep coming, so the block backs up.
  task automatic test_output_stall();
    @(posedge clk_i);
    rx_hold_left = 300;
    for (int i = 0; i < 24; i++)
      send_item(bdr_pkg::VALUE_W'($urandom_range(bdr_pkg::VALUE_RANGE - 1)), i == 23);
    stop_sending();
  endtask

  // Pause the sender mid-list until every result is out, then finish the list.
  task automatic test_drain_pause();
    logic [bdr_pkg::VALUE_W-1:0] base;
    base = bdr_pkg::VALUE_W'($urandom_range(bdr_pkg::VALUE_RANGE - 1));
    for (int i = 0; i < 12; i++)
      send_item(base + bdr_pkg::VALUE_W'($urandom_range(15)), i == 11);
    for (int i = 0; i < 4; i++) send_item(base + bdr_pkg::VALUE_W'($urandom_range(15)), 1'b0);
    stop_sending();
    wait_for_drain();
    for (int i = 0; i < 4; i++) send_item(base + bdr_pkg::VALUE_W'($urandom_range(15)), i == 3);
    stop_sending();
  endtask

  // Lists drawn mostly from a narrow window for duplicates; the window often carries over
  // to the next list to exercise clearing.
  task automatic test_random_lists(input int unsigned n_items);
    int unsigned                 sent;
    int unsigned                 len;
    logic [bdr_pkg::VALUE_W-1:0] window_base;
    logic [bdr_pkg::VALUE_W-1:0] value;
    sent        = 0;
    window_base = bdr_pkg::VALUE_W'($urandom_range(bdr_pkg::VALUE_RANGE - 1));
    while (sent < n_items) begin
      if ($urandom_range(1) == 0)
        window_base = bdr_pkg::VALUE_W'($urandom_range(bdr_pkg::VALUE_RANGE - 1));
      len = ($urandom_range(9) == 0) ? $urandom_range(200, 60) : $urandom_range(24, 1);
      if (len > n_items - sent) len = n_items - sent;
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(3) == 0)
          value = bdr_pkg::VALUE_W'($urandom_range(bdr_pkg::VALUE_RANGE - 1));
        else value = window_base + bdr_pkg::VALUE_W'($urandom_range(31));
        send_item(value, i == len - 1);
      end
      sent += len;
    end
    stop_sending();
  endtask

  // Fill the kept list with neither side idling.
  task automatic test_burst_no_idle();
    @(posedge clk_i);
    no_idle = 1'b1;
    test_list_full();
    @(posedge clk_i);
    no_idle = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 22);
    end
  end

  always @(posedge clk_i) begin : check_results
    bdr_pkg::out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("%0t: unexpected result: expected none, actual %0h", $time, out_data);
      end else begin
        want = awaited_results.pop_front();
        if (out_data.kept_value !== want.kept_value)
          report_field("kept_value", 32'(want.kept_value), 32'(out_data.kept_value));
        if (out_data.kept_count !== want.kept_count)
          report_field("kept_count", 32'(want.kept_count), 32'(out_data.kept_count));
        if (out_data.is_end !== want.is_end)
          report_field("is_end", 32'(want.is_end), 32'(out_data.is_end));
      end
    end
  end

  // Count cycles without any transfer; the reset sweep and a full clear stay well below.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    seen_bytes   = '{default: '0};
    kept_values  = '{default: '0};
    unique_total = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_burst_no_idle();
    test_output_stall();
    test_drain_pause();
    test_random_lists(40);
    wait_for_drain();
    repeat (40) @(posedge clk_i);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
